[sv/gnl_pkg.sv]
// Shared constants and controller-to-datapath command type for the Gaussian noise generator.
package gnl_pkg;

    localparam int SEED_W       = 31;
    localparam int DATA_W       = 32;
    localparam int NUM_SUMS_DEF = 12;

    localparam logic [SEED_W-1:0] LCG_MUL      = 31'd1103515245;
    localparam logic [SEED_W-1:0] LCG_ADD      = 31'd12345;
    localparam logic [SEED_W-1:0] LCG_SEED_RST = 31'd1;

    // input command codes
    localparam logic CMD_GEN  = 1'b0;
    localparam logic CMD_SEED = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // capture the input beat
        logic reseed;    // with accept: load the generator state
        logic step;      // advance the generator once and accumulate
        logic mul_lo;    // low part of the sum times sigma
        logic mul_hi;    // high part of the sum times sigma
        logic combine;   // merge partial products and round
        logic out_load;  // load the output register
        logic out_zero;  // with out_load: reseed result
    } t_dp_cmd;

endpackage

[sv/gnl_ctrl.sv]
// Sequencing state machine: handshakes, step count and output valid.
module gnl_ctrl #(
    parameter int NUM_SUMS = gnl_pkg::NUM_SUMS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_cmd,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    output gnl_pkg::t_dp_cmd o_ctl
);

    localparam int CNT_W = $clog2(NUM_SUMS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_MUL_LO,
        S_MUL_HI,
        S_COMB,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_reseed;
    logic             r_out_valid;

    logic w_accept;
    logic w_slot_free;

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign w_accept    = i_valid && !o_stall;
    assign w_slot_free = !r_out_valid || !i_stall;

    // decode datapath commands from the current state
    always_comb begin
        o_ctl          = '0;
        o_ctl.accept   = w_accept;
        o_ctl.reseed   = w_accept && (i_cmd == gnl_pkg::CMD_SEED);
        o_ctl.step     = (r_state == S_STEP);
        o_ctl.mul_lo   = (r_state == S_MUL_LO);
        o_ctl.mul_hi   = (r_state == S_MUL_HI);
        o_ctl.combine  = (r_state == S_COMB);
        o_ctl.out_load = (r_state == S_OUT) && w_slot_free;
        o_ctl.out_zero = r_reseed;
    end

    // hold state, step count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_reseed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop valid once the beat is taken, unless a new beat loads now
            if (r_out_valid && !i_stall && !o_ctl.out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_cmd == gnl_pkg::CMD_SEED) begin
                            r_reseed <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_reseed <= 1'b0;
                            r_cnt    <= CNT_W'(NUM_SUMS);
                            r_state  <= S_STEP;
                        end
                    end
                end
                S_STEP: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_MUL_LO;
                    end
                end
                S_MUL_LO: begin
                    r_state <= S_MUL_HI;
                end
                S_MUL_HI: begin
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a new result appears only out of the output state
    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("output valid rose outside the output state");

    // a generate beat starts a full run of generator steps
    a_gen_starts_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd == gnl_pkg::CMD_GEN)
            |=> (r_state == S_STEP) && (r_cnt == CNT_W'(NUM_SUMS)))
        else $error("generate beat did not start the step sequence");

    // the step counter never runs out while stepping
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_cnt != '0))
        else $error("step counter empty while stepping");

endmodule

[sv/gnl_dp.sv]
// Datapath: generator state, running sum, split multiply, rounding and saturation.
module gnl_dp #(
    parameter int NUM_SUMS = gnl_pkg::NUM_SUMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gnl_pkg::t_dp_cmd                  i_ctl,
    input  logic        [gnl_pkg::SEED_W-1:0] i_seed_value,
    input  logic signed [gnl_pkg::DATA_W-1:0] i_sigma,
    input  logic signed [gnl_pkg::DATA_W-1:0] i_mean,
    output logic signed [gnl_pkg::DATA_W-1:0] o_sample,
    output logic                              o_saturated,
    output logic        [gnl_pkg::SEED_W-1:0] o_seed_after
);

    localparam int SEED_W = gnl_pkg::SEED_W;
    localparam int DATA_W = gnl_pkg::DATA_W;
    // sum of states, offset-corrected, as a signed value
    localparam int V_W    = SEED_W + $clog2(NUM_SUMS) + 1;
    localparam int LO_W   = 16;
    localparam int HI_W   = V_W - LO_W;
    localparam int PLO_W  = LO_W + 1 + DATA_W;
    localparam int PHI_W  = HI_W + DATA_W;
    localparam int PP_W   = V_W + DATA_W;
    localparam int Q_W    = PP_W - 30;

    localparam logic signed [V_W-1:0]  SUM_INIT = V_W'(64'd0 - (64'(NUM_SUMS) << 30));
    localparam logic signed [PP_W:0]   RND      = (PP_W+1)'(1073741824);
    localparam logic signed [Q_W:0]    SAT_MAX  = (Q_W+1)'(32'h7fffffff);
    localparam logic signed [Q_W:0]    SAT_MIN  = {{(Q_W+1-DATA_W){1'b1}}, 32'h80000000};

    logic        [SEED_W-1:0] r_lcg;
    logic signed [V_W-1:0]    r_sum;
    logic signed [DATA_W-1:0] r_sigma;
    logic signed [DATA_W-1:0] r_mean;
    logic signed [PLO_W-1:0]  r_plo;
    logic signed [PHI_W-1:0]  r_phi;
    logic signed [Q_W-1:0]    r_q;
    logic signed [DATA_W-1:0] r_sample;
    logic                     r_sat;
    logic        [SEED_W-1:0] r_seed_after;

    logic        [SEED_W-1:0] w_lcg_next;
    logic signed [LO_W:0]     w_vl;
    logic signed [HI_W-1:0]   w_vh;
    logic signed [PP_W:0]     w_p;
    logic signed [Q_W:0]      w_r;
    logic signed [DATA_W-1:0] w_clip;
    logic                     w_sat;

    // one generator step, kept to 31 bits
    assign w_lcg_next = r_lcg * gnl_pkg::LCG_MUL + gnl_pkg::LCG_ADD;

    // split the sum into signed high and unsigned low halves
    assign w_vl = {1'b0, r_sum[LO_W-1:0]};
    assign w_vh = r_sum[V_W-1:LO_W];

    // merge partial products and add the rounding half
    assign w_p = {r_phi[PHI_W-1], r_phi, {LO_W{1'b0}}}
               + {{(PP_W+1-PLO_W){r_plo[PLO_W-1]}}, r_plo}
               + RND;

    // add mean and clip to the 32-bit range
    assign w_r = {r_q[Q_W-1], r_q} + {{(Q_W+1-DATA_W){r_mean[DATA_W-1]}}, r_mean};
    always_comb begin
        w_sat  = 1'b0;
        w_clip = w_r[DATA_W-1:0];
        if (w_r > SAT_MAX) begin
            w_sat  = 1'b1;
            w_clip = SAT_MAX[DATA_W-1:0];
        end else if (w_r < SAT_MIN) begin
            w_sat  = 1'b1;
            w_clip = SAT_MIN[DATA_W-1:0];
        end
    end

    // hold generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcg <= gnl_pkg::LCG_SEED_RST;
        end else if (i_ctl.reseed) begin
            r_lcg <= i_seed_value;
        end else if (i_ctl.step) begin
            r_lcg <= w_lcg_next;
        end
    end

    // capture operands, accumulate, multiply in two halves, round, load output
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_sigma <= i_sigma;
            r_mean  <= i_mean;
            r_sum   <= SUM_INIT;
        end
        if (i_ctl.step) begin
            r_sum <= r_sum + $signed({{(V_W-SEED_W){1'b0}}, w_lcg_next});
        end
        if (i_ctl.mul_lo) begin
            r_plo <= w_vl * r_sigma;
        end
        if (i_ctl.mul_hi) begin
            r_phi <= w_vh * r_sigma;
        end
        if (i_ctl.combine) begin
            r_q <= w_p[PP_W:31];
        end
        if (i_ctl.out_load) begin
            r_seed_after <= r_lcg;
            if (i_ctl.out_zero) begin
                r_sample <= '0;
                r_sat    <= 1'b0;
            end else begin
                r_sample <= w_clip;
                r_sat    <= w_sat;
            end
        end
    end

    assign o_sample     = r_sample;
    assign o_saturated  = r_sat;
    assign o_seed_after = r_seed_after;

    // a reseed beat lands the seed in the generator
    a_reseed_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.reseed |=> (r_lcg == $past(i_seed_value)))
        else $error("reseed did not load the generator state");

endmodule

[sv/gaussian_noise_lcg_sum12.sv]
// Generate: the beat is accepted, then NUM_SUMS generator steps (the LCG recurrence,
// one 31-bit multiply per cycle) accumulate the sum, then come the low and high sigma
// partial products, a combine and rounding step, and the mean add and saturation as the
// output register loads. No new beat is taken until the controller is idle again.
// Reseed: the seed loads the generator state on acceptance, then the zero result loads.
// Reset (synchronous, active low) sets the generator state to 1 and clears output valid;
// a stalled result holds the output register and delays the next one.
module gaussian_noise_lcg_sum12 #(
    parameter int NUM_SUMS = gnl_pkg::NUM_SUMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_cmd,
    input  logic        [gnl_pkg::SEED_W-1:0] i_seed_value,
    input  logic signed [gnl_pkg::DATA_W-1:0] i_sigma,
    input  logic signed [gnl_pkg::DATA_W-1:0] i_mean,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [gnl_pkg::DATA_W-1:0] o_sample,
    output logic                              o_saturated,
    output logic        [gnl_pkg::SEED_W-1:0] o_seed_after
);

    gnl_pkg::t_dp_cmd w_ctl;

    // sequence the work
    gnl_ctrl #(
        .NUM_SUMS (NUM_SUMS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_ctl   (w_ctl)
    );

    // compute the sample
    gnl_dp #(
        .NUM_SUMS (NUM_SUMS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_seed_value (i_seed_value),
        .i_sigma      (i_sigma),
        .i_mean       (i_mean),
        .o_sample     (o_sample),
        .o_saturated  (o_saturated),
        .o_seed_after (o_seed_after)
    );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the LCG sum-of-twelve Gaussian noise generator.
module tb_top;

    localparam int SEED_W       = gnl_pkg::SEED_W;
    localparam int DATA_W       = gnl_pkg::DATA_W;
    localparam int SUM_COUNT    = gnl_pkg::NUM_SUMS_DEF;
    localparam int RANDOM_BEATS = 628;
    localparam int PHASE_BEATS  = 40;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [79:0] ROUND_HALF = 80'sd1073741824;
    localparam logic signed [79:0] SAMPLE_MAX = 80'sd2147483647;
    localparam logic signed [79:0] SAMPLE_MIN = -80'sd2147483648;

    typedef struct {
        logic                     cmd;
        logic        [SEED_W-1:0] seed;
        logic signed [DATA_W-1:0] sigma;
        logic signed [DATA_W-1:0] mean;
    } t_noise_req;

    typedef struct {
        logic signed [DATA_W-1:0] sample;
        logic                     saturated;
        logic        [SEED_W-1:0] seed_after;
    } t_noise_res;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_valid      = 1'b0;
    logic                     o_stall;
    logic                     i_cmd        = gnl_pkg::CMD_GEN;
    logic        [SEED_W-1:0] i_seed_value = '0;
    logic signed [DATA_W-1:0] i_sigma      = '0;
    logic signed [DATA_W-1:0] i_mean       = '0;
    logic                     o_valid;
    logic                     i_stall      = 1'b0;
    logic signed [DATA_W-1:0] o_sample;
    logic                     o_saturated;
    logic        [SEED_W-1:0] o_seed_after;

    t_noise_req  pending_q[$];
    t_noise_res  sample_q[$];
    t_noise_req  held_req;
    logic [SEED_W-1:0] gen_state = gnl_pkg::LCG_SEED_RST;
    int          beats_taken = 0;
    int          total_beats = 0;
    int          mismatches  = 0;
    int          cycle_count = 0;

    gaussian_noise_lcg_sum12 dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_seed_value (i_seed_value),
        .i_sigma      (i_sigma),
        .i_mean       (i_mean),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample     (o_sample),
        .o_saturated  (o_saturated),
        .o_seed_after (o_seed_after)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Advance the generator state and work out the sample for one beat
    function automatic t_noise_res predict_noise(input t_noise_req req);
        t_noise_res        res;
        logic [SEED_W-1:0] s;
        longint            acc;
        logic signed [79:0] prod;
        logic signed [79:0] shifted;
        res.sample    = '0;
        res.saturated = 1'b0;
        if (req.cmd == gnl_pkg::CMD_SEED) begin
            gen_state      = req.seed;
            res.seed_after = req.seed;
            return res;
        end
        s   = gen_state;
        acc = 0;
        for (int k = 0; k < SUM_COUNT; k++) begin
            s   = s * gnl_pkg::LCG_MUL + gnl_pkg::LCG_ADD;
            acc = acc + longint'(s);
        end
        gen_state = s;
        // center the sum, scale by sigma, round to Q16.16, add the mean
        prod    = acc - longint'(SUM_COUNT) * 64'sd1073741824;
        prod    = prod * req.sigma;
        shifted = (prod + ROUND_HALF) >>> 31;
        shifted = shifted + req.mean;
        if (shifted > SAMPLE_MAX) begin
            res.sample    = SAMPLE_MAX[DATA_W-1:0];
            res.saturated = 1'b1;
        end else if (shifted < SAMPLE_MIN) begin
            res.sample    = SAMPLE_MIN[DATA_W-1:0];
            res.saturated = 1'b1;
        end else begin
            res.sample = shifted[DATA_W-1:0];
        end
        res.seed_after = s;
        return res;
    endfunction

    // Pick a Q16.16 value: mostly modest, sometimes full range or an extreme
    function automatic logic signed [DATA_W-1:0] pick_q16();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return $signed(32'($urandom_range(1 << 20))) - 32'sd524288;
        else if (sel < 60)
            return $signed(32'($urandom_range(1 << 25))) - 32'sd16777216;
        else if (sel < 90)
            return $signed($urandom);
        case ($urandom_range(4))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sh00000000;
            3: return 32'sh00000001;
            default: return 32'shffffffff;
        endcase
    endfunction

    function automatic logic [SEED_W-1:0] pick_seed();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        return SEED_W'($urandom);
    endfunction

    function automatic int idle_phase();
        return (beats_taken / PHASE_BEATS) % 4;
    endfunction

    // Sender idles half the time in phase one, a tenth in phase three
    function automatic bit sender_idle();
        int ph;
        ph = idle_phase();
        if (ph == 1)
            return $urandom_range(99) < 50;
        if (ph == 3)
            return $urandom_range(99) < 10;
        return 1'b0;
    endfunction

    function automatic bit receiver_stall();
        int ph;
        ph = idle_phase();
        if (ph == 2)
            return $urandom_range(99) < 50;
        if (ph == 3)
            return $urandom_range(99) < 10;
        return 1'b0;
    endfunction

    task automatic add_beat(input logic cmd, input logic [SEED_W-1:0] seed,
                            input logic signed [DATA_W-1:0] sigma,
                            input logic signed [DATA_W-1:0] mean);
        t_noise_req req;
        req.cmd   = cmd;
        req.seed  = seed;
        req.sigma = sigma;
        req.mean  = mean;
        pending_q.push_back(req);
    endtask

    // Compare one result beat against the oldest prediction
    task automatic check_sample();
        t_noise_res want;
        if (sample_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected result beat: sample %0d sat %0b seed %0d",
                         o_sample, o_saturated, o_seed_after);
            return;
        end
        want = sample_q.pop_front();
        if (o_sample !== want.sample || o_saturated !== want.saturated ||
            o_seed_after !== want.seed_after) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display({"mismatch: exp sample %0d sat %0b seed %0d, ",
                          "got sample %0d sat %0b seed %0d"},
                         want.sample, want.saturated, want.seed_after,
                         o_sample, o_saturated, o_seed_after);
        end
    endtask

    // Driver: hold the beat while stalled, predict on accept, load the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                sample_q.push_back(predict_noise(held_req));
                beats_taken <= beats_taken + 1;
            end
            if (!i_valid || !o_stall) begin
                if (pending_q.size() > 0 && !sender_idle()) begin
                    held_req = pending_q.pop_front();
                    i_valid      <= 1'b1;
                    i_cmd        <= held_req.cmd;
                    i_seed_value <= held_req.seed;
                    i_sigma      <= held_req.sigma;
                    i_mean       <= held_req.mean;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check accepted results, stall at random per phase
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                check_sample();
            i_stall <= receiver_stall();
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        // directed: reset seed, field extremes, saturation both ways
        add_beat(gnl_pkg::CMD_GEN, '0, 32'sh00010000, 32'sh00000000);
        add_beat(gnl_pkg::CMD_GEN, '0, 32'sh00000000, 32'sh7fffffff);
        add_beat(gnl_pkg::CMD_GEN, '1, 32'sh00000000, 32'sh80000000);
        add_beat(gnl_pkg::CMD_GEN, '0, 32'sh7fffffff, 32'sh7fffffff);
        add_beat(gnl_pkg::CMD_GEN, '1, 32'sh80000000, 32'sh80000000);
        add_beat(gnl_pkg::CMD_GEN, '0, 32'sh7fffffff, 32'sh00000000);
        add_beat(gnl_pkg::CMD_GEN, '0, 32'sh80000000, 32'sh00000000);
        add_beat(gnl_pkg::CMD_GEN, '0, 32'shffffffff, 32'sh00000001);
        // reseed with zero, then run from it; reseed output must be zero
        add_beat(gnl_pkg::CMD_SEED, '0, 32'sh7fffffff, 32'sh7fffffff);
        add_beat(gnl_pkg::CMD_GEN, '0, 32'sh00010000, 32'sh00000000);
        add_beat(gnl_pkg::CMD_SEED, '1, 32'sh80000000, 32'sh80000000);
        add_beat(gnl_pkg::CMD_GEN, '0, 32'sh00010000, 32'sh00010000);
        // negative sigma mirrors the same draw around the mean
        add_beat(gnl_pkg::CMD_SEED, 31'h12345678, 32'sh00000000, 32'sh00000000);
        add_beat(gnl_pkg::CMD_GEN, '0, 32'sh00030000, 32'sh00050000);
        add_beat(gnl_pkg::CMD_SEED, 31'h12345678, 32'sh00000000, 32'sh00000000);
        add_beat(gnl_pkg::CMD_GEN, '0, -32'sh00030000, 32'sh00050000);
        add_beat(gnl_pkg::CMD_GEN, '0, 32'sh00000001, 32'shffffffff);
        add_beat(gnl_pkg::CMD_SEED, 31'd1, 32'sh00000000, 32'sh00000000);
        add_beat(gnl_pkg::CMD_GEN, '0, 32'sh00010000, 32'sh00000000);
        add_beat(gnl_pkg::CMD_GEN, '1, 32'sh00008000, 32'sh0000ffff);

        // random: mostly generate, some reseeds
        repeat (RANDOM_BEATS) begin
            if ($urandom_range(99) < 15)
                add_beat(gnl_pkg::CMD_SEED, pick_seed(), pick_q16(), pick_q16());
            else
                add_beat(gnl_pkg::CMD_GEN, pick_seed(), pick_q16(), pick_q16());
        end
        total_beats = pending_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_taken < total_beats || sample_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && sample_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
